// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// needs clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, off while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/udpp_pkg.sv =====
// types and constants of the udp frame parser
// no dependencies
package udpp_pkg;

  typedef enum logic [2:0] {
    VD_OK           = 3'd0,
    VD_SHORT        = 3'd1,
    VD_NOT_IPV4     = 3'd2,
    VD_NOT_UDP      = 3'd3,
    VD_LEN_MISMATCH = 3'd4,
    VD_UDP_SHORT    = 3'd5,
    VD_BEYOND_FRAME = 3'd6,
    VD_TOO_LONG     = 3'd7
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] HDR_END        = 16'd42;
  localparam logic [15:0] IP_HDR_LEN     = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  // byte offsets of the captured header fields
  localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
  localparam logic [15:0] POS_TLEN_HI    = 16'd16;
  localparam logic [15:0] POS_TLEN_LO    = 16'd17;
  localparam logic [15:0] POS_PROTO      = 16'd23;
  localparam logic [15:0] POS_SRC_0      = 16'd26;
  localparam logic [15:0] POS_SRC_1      = 16'd27;
  localparam logic [15:0] POS_SRC_2      = 16'd28;
  localparam logic [15:0] POS_SRC_3      = 16'd29;
  localparam logic [15:0] POS_SPORT_HI   = 16'd34;
  localparam logic [15:0] POS_SPORT_LO   = 16'd35;
  localparam logic [15:0] POS_DPORT_HI   = 16'd36;
  localparam logic [15:0] POS_DPORT_LO   = 16'd37;
  localparam logic [15:0] POS_ULEN_HI    = 16'd38;
  localparam logic [15:0] POS_ULEN_LO    = 16'd39;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    verdict_t    verdict;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_length;
    logic        run_end;
  } result_t;

  // results produced by one accepted byte, first goes out first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== sv/udp_frame_parser_unit.sv =====
// udp frame parser top level: byte stream in, payload and verdict stream out
// depends on udpp_pkg, udpp_parse, udpp_result_q and assert_macros.svh
//
// takes an ethernet frame one byte per cycle (tlast on the final byte), assumes
// fixed 14-byte ethernet, 20-byte ipv4 and 8-byte udp headers and captures
// ethertype, ip total length, protocol, source address, ports and udp length.
// from byte 42 on, payload bytes are passed on as soon as the header checks
// that are already decidable pass (tuser 0); the udp-length-beyond-frame check
// can only be made at frame end, so passed bytes may still end in a reject.
// on the final byte a verdict request follows (tuser 1), after the payload
// request of that byte if there is one; tlast marks the last request caused
// by an input byte. its results are built in the same cycle it is accepted and
// written into a QUEUE_DEPTH-entry result queue that drains one request per
// cycle, so the rate is one byte per cycle as long as the consumer takes a
// request per cycle; a frame-end byte that also carries payload writes two
// entries. in_tready drops only when the queue holds more than QUEUE_DEPTH-2
// entries. max_payload (reset 1472) is written through cfg_we/cfg_wdata by the
// user only while the parser is idle; not enforced. checksums are not checked.

`include "assert_macros.svh"

module udp_frame_parser_unit #(
  parameter int QUEUE_DEPTH = 4   // result queue entries, at least 2
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  input  logic        in_tlast,    // frame_end

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [10:8] verdict, [42:11] source_address,
  // [58:43] source_port, [74:59] destination_port, [90:75] payload_length,
  // [95:91] zero
  output logic [95:0] out_tdata,
  output logic        out_tuser,   // item_kind
  output logic        out_tlast,   // run_end

  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata    // max_payload
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]       max_payload_r;
  logic              in_acc;
  udpp_pkg::push_t   push;
  udpp_pkg::result_t head;
  logic              head_valid;
  logic              room;
  logic [CW-1:0]     level;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'd1472;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  // ready only depends on queue fill, never on the output side this cycle
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  udpp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (in_acc),
    .frame_byte  (in_tdata),
    .frame_end   (in_tlast),
    .max_payload (max_payload_r),
    .push        (push)
  );

  udpp_result_q #(
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head       (head),
    .head_valid (head_valid),
    .room       (room),
    .level      (level)
  );

  // pack the head request onto the output stream
  assign out_tvalid = head_valid;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_end;
  assign out_tdata  = {5'b0, head.payload_length, head.destination_port,
                       head.source_port, head.source_address, head.verdict,
                       head.payload_byte};

  // queue never holds more than its depth
  `ASSERT_CLK(a_level_bound, level <= CW'(QUEUE_DEPTH), "result queue overflow")
  // a verdict always closes the run of its byte
  `ASSERT_IMPLIES(a_verdict_last, out_tvalid && (out_tuser == udpp_pkg::KIND_VERDICT), out_tlast, "verdict without tlast")
  // without an accepted byte the queue can only drain
  `ASSERT_NEXT(a_no_phantom, !in_acc, level <= $past(level), "queue grew without input")

endmodule

// ===== sv/udpp_parse.sv =====
// header capture, checks and result build for one frame byte
// depends on udpp_pkg
module udpp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_en,
  input  logic [7:0]           frame_byte,
  input  logic                 frame_end,
  input  logic [15:0]          max_payload,
  output udpp_pkg::push_t      push
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [31:0] src_r, src_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] ulen_r, ulen_nxt;

  logic [15:0] pay_len;
  logic        early_ok;
  logic        pay_fit;
  logic        pay_emit;
  udpp_pkg::verdict_t early_vd;
  udpp_pkg::verdict_t final_vd;
  udpp_pkg::result_t  pay_res;
  udpp_pkg::result_t  vd_res;

  // field capture, big endian
  always_comb begin
    etype_nxt = etype_r;
    tlen_nxt  = tlen_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    ulen_nxt  = ulen_r;
    unique case (pos_r)
      udpp_pkg::POS_ETYPE_HI, udpp_pkg::POS_ETYPE_LO: etype_nxt = {etype_r[7:0], frame_byte};
      udpp_pkg::POS_TLEN_HI, udpp_pkg::POS_TLEN_LO:   tlen_nxt  = {tlen_r[7:0], frame_byte};
      udpp_pkg::POS_PROTO:                            proto_nxt = frame_byte;
      udpp_pkg::POS_SRC_0, udpp_pkg::POS_SRC_1,
      udpp_pkg::POS_SRC_2, udpp_pkg::POS_SRC_3:       src_nxt   = {src_r[23:0], frame_byte};
      udpp_pkg::POS_SPORT_HI, udpp_pkg::POS_SPORT_LO: sport_nxt = {sport_r[7:0], frame_byte};
      udpp_pkg::POS_DPORT_HI, udpp_pkg::POS_DPORT_LO: dport_nxt = {dport_r[7:0], frame_byte};
      udpp_pkg::POS_ULEN_HI, udpp_pkg::POS_ULEN_LO:   ulen_nxt  = {ulen_r[7:0], frame_byte};
      default: ;
    endcase
  end

  // position restarts after frame end, saturates on long frames
  always_comb begin
    pos_nxt = pos_r;
    if (frame_end) begin
      pos_nxt = '0;
    end else if (pos_r != udpp_pkg::POS_MAX) begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  // header checks; all fields are complete before the first check position
  always_comb begin
    priority if (etype_r != udpp_pkg::ETHERTYPE_IPV4) begin
      early_vd = udpp_pkg::VD_NOT_IPV4;
    end else if (proto_r != udpp_pkg::PROTO_UDP) begin
      early_vd = udpp_pkg::VD_NOT_UDP;
    end else if ({1'b0, tlen_r} != ({1'b0, ulen_r} + {1'b0, udpp_pkg::IP_HDR_LEN})) begin
      early_vd = udpp_pkg::VD_LEN_MISMATCH;
    end else if (ulen_r < udpp_pkg::UDP_HDR_LEN) begin
      early_vd = udpp_pkg::VD_UDP_SHORT;
    end else begin
      early_vd = udpp_pkg::VD_OK;
    end
  end

  assign early_ok = (early_vd == udpp_pkg::VD_OK);
  assign pay_len  = ulen_r - udpp_pkg::UDP_HDR_LEN;
  assign pay_fit  = (pay_len <= max_payload);
  assign pay_emit = (pos_r >= udpp_pkg::HDR_END) && early_ok && pay_fit &&
                    ({1'b0, pos_r} < ({1'b0, udpp_pkg::HDR_END} + {1'b0, pay_len}));

  // frame end verdict; frame length is pos + 1
  always_comb begin
    priority if (pos_r < (udpp_pkg::HDR_END - 16'd1)) begin
      final_vd = udpp_pkg::VD_SHORT;
    end else if (!early_ok) begin
      final_vd = early_vd;
    end else if (ulen_r > (pos_r - (udpp_pkg::HDR_END - 16'd1))) begin
      final_vd = udpp_pkg::VD_BEYOND_FRAME;
    end else if (!pay_fit) begin
      final_vd = udpp_pkg::VD_TOO_LONG;
    end else begin
      final_vd = udpp_pkg::VD_OK;
    end
  end

  always_comb begin
    pay_res                = '0;
    pay_res.kind           = udpp_pkg::KIND_PAYLOAD;
    pay_res.payload_byte   = frame_byte;
    pay_res.verdict        = udpp_pkg::VD_OK;
    pay_res.run_end        = !frame_end;

    vd_res                 = '0;
    vd_res.kind            = udpp_pkg::KIND_VERDICT;
    vd_res.verdict         = final_vd;
    vd_res.run_end         = 1'b1;
    if (final_vd == udpp_pkg::VD_OK) begin
      vd_res.source_address   = src_r;
      vd_res.source_port      = sport_r;
      vd_res.destination_port = dport_r;
      vd_res.payload_length   = pay_len;
    end
  end

  always_comb begin
    push.first  = pay_emit ? pay_res : vd_res;
    push.second = vd_res;
    if (!byte_en) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = 2'({1'b0, pay_emit} + {1'b0, frame_end});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      proto_r <= '0;
      tlen_r  <= '0;
      src_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
      ulen_r  <= '0;
    end else if (byte_en) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      tlen_r  <= tlen_nxt;
      src_r   <= src_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      ulen_r  <= ulen_nxt;
    end
  end

endmodule

// ===== sv/udpp_result_q.sv =====
// small result queue: up to two writes, one read per cycle
// depends on udpp_pkg
module udpp_result_q #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  udpp_pkg::push_t              push,
  input  logic                         pop,
  output udpp_pkg::result_t            head,
  output logic                         head_valid,
  output logic                         room,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  udpp_pkg::result_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wr_ptr_p1;
  logic          do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign do_pop     = pop && (cnt_r != '0);
  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign room       = (cnt_r <= CW'(DEPTH - 2));
  assign level      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    unique case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: ;
    endcase
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== bench/tb_udp_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// self-checking bench for udp_frame_parser_unit: ethernet/ipv4/udp frames in, payload
// and verdict requests out, checked against a behavioral parser kept in this file
// depends on udpp_pkg and the rtl of udp_frame_parser_unit
module tb_udp_frame_parser_unit;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // one frame to build and send; typed rows carry the verdict read off by hand
  typedef struct packed {
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] tlen;
    logic [15:0] ulen;
    logic [31:0] src;
    logic [15:0] sport;
    logic [15:0] dport;
    int unsigned flen;
    logic [15:0] mp;
    bit          typed;
    udpp_pkg::verdict_t vd;
  } frame_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // header fields as the parser has captured them so far
  logic [15:0] byte_pos = '0;
  logic [15:0] hdr_etype = '0;
  logic [7:0]  hdr_proto = '0;
  logic [15:0] hdr_ip_len = '0;
  logic [31:0] hdr_src = '0;
  logic [15:0] hdr_sport = '0;
  logic [15:0] hdr_dport = '0;
  logic [15:0] hdr_udp_len = '0;
  logic [15:0] max_pay_cfg = 16'd1472;

  // payload and verdict requests still owed by the block, oldest first
  udpp_pkg::result_t frame_results_q [$];
  logic [7:0]  frame_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned rx_hold_req = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned payload_checked = 0;
  int unsigned verdicts_checked = 0;
  logic [7:0]  verdict_hit = '0;

  // hand-written corner frames; typed rows are checked against the verdict column
  frame_case_t directed_cases [0:10] = '{
    // one byte and 41 bytes: both too short to hold the headers
    '{16'h0800, 8'd17, 16'd28, 16'd8, 32'hC0A8_0001, 16'd1000, 16'd2000, 1,
      16'd1472, 1'b1, udpp_pkg::VD_SHORT},
    '{16'h0800, 8'd17, 16'd28, 16'd8, 32'hC0A8_0001, 16'd1000, 16'd2000, 41,
      16'd1472, 1'b1, udpp_pkg::VD_SHORT},
    // smallest accepted frame, extreme address and port values
    '{16'h0800, 8'd17, 16'd28, 16'd8, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 50,
      16'd1472, 1'b1, udpp_pkg::VD_OK},
    '{16'h86DD, 8'd17, 16'd28, 16'd8, 32'h0A00_0001, 16'd1, 16'd2, 42,
      16'd1472, 1'b1, udpp_pkg::VD_NOT_IPV4},
    '{16'h0800, 8'd6, 16'd28, 16'd8, 32'h0A00_0001, 16'd1, 16'd2, 42,
      16'd1472, 1'b1, udpp_pkg::VD_NOT_UDP},
    '{16'h0800, 8'd17, 16'd20, 16'd0, 32'h0A00_0001, 16'd1, 16'd2, 42,
      16'd1472, 1'b1, udpp_pkg::VD_UDP_SHORT},
    // udp length plus 20 overflows 16 bits and must not wrap onto the ip length
    '{16'h0800, 8'd17, 16'h0000, 16'hFFEC, 32'h0102_0304, 16'd9, 16'd9, 42,
      16'd1472, 1'b1, udpp_pkg::VD_LEN_MISMATCH},
    // final byte is itself payload: payload request first, verdict second
    '{16'h0800, 8'd17, 16'd36, 16'd16, 32'h0A00_0001, 16'd53, 16'd5353, 50,
      16'd1472, 1'b1, udpp_pkg::VD_BEYOND_FRAME},
    // trailing bytes after the payload are dropped
    '{16'h0800, 8'd17, 16'd30, 16'd10, 32'h7F00_0001, 16'd4242, 16'd80, 54,
      16'd1472, 1'b0, udpp_pkg::VD_OK},
    // max_payload at zero: empty payload passes, one byte is too long
    '{16'h0800, 8'd17, 16'd28, 16'd8, 32'h5555_AAAA, 16'h5555, 16'hAAAA, 50,
      16'd0, 1'b1, udpp_pkg::VD_OK},
    '{16'h0800, 8'd17, 16'd29, 16'd9, 32'h5555_AAAA, 16'h5555, 16'hAAAA, 51,
      16'd0, 1'b1, udpp_pkg::VD_TOO_LONG}
  };

  udp_frame_parser_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycle_count,
               frame_results_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // checks that need only the captured header, not the frame length
  function automatic udpp_pkg::verdict_t header_verdict();
    if (hdr_etype != udpp_pkg::ETHERTYPE_IPV4) return udpp_pkg::VD_NOT_IPV4;
    if (hdr_proto != udpp_pkg::PROTO_UDP) return udpp_pkg::VD_NOT_UDP;
    if (32'(hdr_ip_len) != 32'(hdr_udp_len) + 32'(udpp_pkg::IP_HDR_LEN))
      return udpp_pkg::VD_LEN_MISMATCH;
    if (hdr_udp_len < udpp_pkg::UDP_HDR_LEN) return udpp_pkg::VD_UDP_SHORT;
    return udpp_pkg::VD_OK;
  endfunction

  // one accepted byte: update the captured header, queue the requests it causes
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    int unsigned pos_now;
    int unsigned pay;
    int unsigned flen;
    udpp_pkg::verdict_t vd;
    udpp_pkg::result_t  r;
    pos_now = byte_pos;
    case (byte_pos)
      udpp_pkg::POS_ETYPE_HI, udpp_pkg::POS_ETYPE_LO: hdr_etype = {hdr_etype[7:0], b};
      udpp_pkg::POS_TLEN_HI, udpp_pkg::POS_TLEN_LO:   hdr_ip_len = {hdr_ip_len[7:0], b};
      udpp_pkg::POS_PROTO:                            hdr_proto = b;
      udpp_pkg::POS_SRC_0, udpp_pkg::POS_SRC_1,
      udpp_pkg::POS_SRC_2, udpp_pkg::POS_SRC_3:       hdr_src = {hdr_src[23:0], b};
      udpp_pkg::POS_SPORT_HI, udpp_pkg::POS_SPORT_LO: hdr_sport = {hdr_sport[7:0], b};
      udpp_pkg::POS_DPORT_HI, udpp_pkg::POS_DPORT_LO: hdr_dport = {hdr_dport[7:0], b};
      udpp_pkg::POS_ULEN_HI, udpp_pkg::POS_ULEN_LO:   hdr_udp_len = {hdr_udp_len[7:0], b};
      default: ;
    endcase
    vd = header_verdict();
    pay = 32'(hdr_udp_len) - 32'(udpp_pkg::UDP_HDR_LEN);
    if (pos_now >= udpp_pkg::HDR_END && vd == udpp_pkg::VD_OK && pay <= max_pay_cfg &&
        pos_now < 32'(udpp_pkg::HDR_END) + pay) begin
      r = '0;
      r.kind = udpp_pkg::KIND_PAYLOAD;
      r.payload_byte = b;
      r.run_end = ~last;
      frame_results_q.push_back(r);
    end
    if (last) begin
      flen = pos_now + 1;
      if (flen < udpp_pkg::HDR_END) vd = udpp_pkg::VD_SHORT;
      else if (vd == udpp_pkg::VD_OK) begin
        if (32'(hdr_udp_len) > flen - udpp_pkg::HDR_END) vd = udpp_pkg::VD_BEYOND_FRAME;
        else if (pay > max_pay_cfg) vd = udpp_pkg::VD_TOO_LONG;
      end
      r = '0;
      r.kind = udpp_pkg::KIND_VERDICT;
      r.verdict = vd;
      r.run_end = 1'b1;
      if (vd == udpp_pkg::VD_OK) begin
        r.source_address = hdr_src;
        r.source_port = hdr_sport;
        r.destination_port = hdr_dport;
        r.payload_length = pay[15:0];
      end
      frame_results_q.push_back(r);
      byte_pos = '0;
    end else if (byte_pos != udpp_pkg::POS_MAX) begin
      byte_pos = byte_pos + 16'd1;
    end
  endfunction

  function automatic void fill_frame(input frame_case_t c);
    logic [7:0] v;
    frame_bytes.delete();
    for (int i = 0; i < int'(c.flen); i++) begin
      v = 8'($urandom);
      case (i)
        udpp_pkg::POS_ETYPE_HI: v = c.etype[15:8];
        udpp_pkg::POS_ETYPE_LO: v = c.etype[7:0];
        udpp_pkg::POS_TLEN_HI:  v = c.tlen[15:8];
        udpp_pkg::POS_TLEN_LO:  v = c.tlen[7:0];
        udpp_pkg::POS_PROTO:    v = c.proto;
        udpp_pkg::POS_SRC_0:    v = c.src[31:24];
        udpp_pkg::POS_SRC_1:    v = c.src[23:16];
        udpp_pkg::POS_SRC_2:    v = c.src[15:8];
        udpp_pkg::POS_SRC_3:    v = c.src[7:0];
        udpp_pkg::POS_SPORT_HI: v = c.sport[15:8];
        udpp_pkg::POS_SPORT_LO: v = c.sport[7:0];
        udpp_pkg::POS_DPORT_HI: v = c.dport[15:8];
        udpp_pkg::POS_DPORT_LO: v = c.dport[7:0];
        udpp_pkg::POS_ULEN_HI:  v = c.ulen[15:8];
        udpp_pkg::POS_ULEN_LO:  v = c.ulen[7:0];
        default: ;
      endcase
      frame_bytes.push_back(v);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // sender: random gaps, then hold the request until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_case_t c);
    udpp_pkg::result_t r;
    fill_frame(c);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    // typed rows: the verdict request just queued is replaced by the hand-read one
    if (c.typed) begin
      r = '0;
      r.kind = udpp_pkg::KIND_VERDICT;
      r.verdict = c.vd;
      r.run_end = 1'b1;
      if (c.vd == udpp_pkg::VD_OK) begin
        r.source_address = c.src;
        r.source_port = c.sport;
        r.destination_port = c.dport;
        r.payload_length = c.ulen - udpp_pkg::UDP_HDR_LEN;
      end
      frame_results_q[frame_results_q.size() - 1] = r;
    end
    frames_sent++;
  endtask

  // mostly well-formed frames with random content, the rest broken on purpose
  task automatic random_frame();
    frame_case_t c;
    int unsigned pick;
    c = '0;
    c.etype = udpp_pkg::ETHERTYPE_IPV4;
    c.proto = udpp_pkg::PROTO_UDP;
    c.ulen = udpp_pkg::UDP_HDR_LEN + 16'($urandom_range(0, 24));
    c.tlen = c.ulen + udpp_pkg::IP_HDR_LEN;
    c.src = $urandom;
    c.sport = 16'($urandom);
    c.dport = 16'($urandom);
    c.flen = 32'(udpp_pkg::HDR_END) + c.ulen + $urandom_range(0, 3);
    c.vd = udpp_pkg::VD_OK;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // cut inside the payload
      c.flen = $urandom_range(32'(udpp_pkg::HDR_END), 32'(udpp_pkg::HDR_END) + c.ulen - 1);
    end else if (pick >= 70) begin
      case ($urandom_range(0, 5))
        0: c.flen = $urandom_range(1, 32'(udpp_pkg::HDR_END) - 1);
        1: c.etype = c.etype ^ (16'd1 << $urandom_range(0, 15));
        2: c.proto = c.proto ^ 8'($urandom_range(1, 255));
        3: c.tlen = c.tlen ^ 16'($urandom_range(1, 65535));
        4: begin
          c.ulen = 16'($urandom_range(0, 7));
          c.tlen = c.ulen + udpp_pkg::IP_HDR_LEN;
        end
        default: begin
          c.etype = 16'($urandom);
          c.proto = 8'($urandom);
          c.tlen = 16'($urandom);
          c.ulen = 16'($urandom);
          c.flen = $urandom_range(32'(udpp_pkg::HDR_END), 80);
        end
      endcase
    end
    send_frame(c);
  endtask

  // stop offering and wait until every owed request has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_pay_cfg = v;
    cfg_writes++;
  endtask

  // handshake mix: 0 none, 1 sender idle, 2 receiver stalls, 3 both lightly
  task automatic set_idle_mode(input int mode);
    send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 27 : 0;
    stall_pct = (mode == 2) ? 53 : (mode == 3) ? 27 : 0;
  endtask

  // receiver: check each accepted request, then pick the next tready
  initial begin
    int unsigned hold_left;
    udpp_pkg::result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          $error("request with nothing owed: tuser %0b tlast %0b tdata 0x%0h",
                 out_tuser, out_tlast, out_tdata);
          error_count++;
        end else begin
          want = frame_results_q.pop_front();
          compare_field("item_kind", want.kind, out_tuser);
          compare_field("payload_byte", want.payload_byte, out_tdata[7:0]);
          compare_field("verdict", want.verdict, out_tdata[10:8]);
          compare_field("source_address", want.source_address, out_tdata[42:11]);
          compare_field("source_port", want.source_port, out_tdata[58:43]);
          compare_field("destination_port", want.destination_port, out_tdata[74:59]);
          compare_field("payload_length", want.payload_length, out_tdata[90:75]);
          compare_field("tdata_pad", '0, out_tdata[95:91]);
          compare_field("run_end", want.run_end, out_tlast);
          if (want.kind == udpp_pkg::KIND_VERDICT) begin
            verdicts_checked++;
            verdict_hit[want.verdict] = 1'b1;
          end else begin
            payload_checked++;
          end
        end
      end
      // a long hold-off asked for by the sender side, counted here
      if (hold_left == 0 && rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (!rst_n) out_tready <= 1'b0;
      else if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // stimulus: directed frames, then four random phases
  initial begin
    logic [15:0] phase_max_pay [0:3];
    int unsigned phase_bytes;
    int unsigned phase_frames;
    phase_max_pay[0] = 16'd24;
    phase_max_pay[1] = 16'hFFFF;
    phase_max_pay[2] = 16'($urandom_range(4, 30));
    phase_max_pay[3] = 16'd12;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first rows run on the reset value of max_payload
    set_idle_mode(0);
    foreach (directed_cases[i]) begin
      if (directed_cases[i].mp != max_pay_cfg) begin
        settle();
        write_max_payload(directed_cases[i].mp);
      end
      send_frame(directed_cases[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_max_payload(phase_max_pay[ph]);
      set_idle_mode(ph);
      phase_bytes = bytes_sent;
      phase_frames = 0;
      // receiver holds off while frames keep coming, so the input backs up
      if (ph == 0) rx_hold_req = 150;
      while (bytes_sent - phase_bytes < 40 || phase_frames < ((ph == 0) ? 2 : 1)) begin
        random_frame();
        phase_frames++;
        // sender pauses after the first frame until the block has drained
        if (ph == 2 && phase_frames == 1) settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("sent %0d frames (%0d bytes) under %0d max_payload writes and four idle mixes",
             frames_sent, bytes_sent, cfg_writes);
    $display("checked %0d payload and %0d verdict requests, %0d of 8 verdict codes seen",
             payload_checked, verdicts_checked, $countones(verdict_hit));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
